@@ hdl/sl2l_pkg.sv @@
// ---------------------------------------------------------------------------
// sl2l_pkg
// Shared widths, entry and pair codes, column codes and the product and
// quantity types of the SL(2,C) to Lorentz matrix converter.
// ---------------------------------------------------------------------------
package sl2l_pkg;

  localparam int IN_W   = 32;               // Q8.24 entry
  localparam int PROD_W = 2 * IN_W;         // exact product, Q16.48
  localparam int QNT_W  = PROD_W + 1;       // sum of two products
  localparam int SUM_W  = 74;               // row accumulator, modulo 2^SUM_W
  localparam int ROW_W  = 48;               // Q24.24 result row
  localparam int SH_HALF = 25;              // rows zero and one carry 1/2
  localparam int SH_FULL = 24;

  // Matrix entries.
  localparam logic [1:0] ENT_A = 2'd0;
  localparam logic [1:0] ENT_B = 2'd1;
  localparam logic [1:0] ENT_C = 2'd2;
  localparam logic [1:0] ENT_D = 2'd3;

  // Entry pairs (x, y) for which x * conj(y) is formed.
  localparam int NPAIR = 6;
  localparam logic [2:0] PR_AC = 3'd0;
  localparam logic [2:0] PR_BD = 3'd1;
  localparam logic [2:0] PR_AB = 3'd2;
  localparam logic [2:0] PR_CD = 3'd3;
  localparam logic [2:0] PR_AD = 3'd4;
  localparam logic [2:0] PR_BC = 3'd5;

  localparam logic [1:0] PAIR_X [NPAIR] = '{ENT_A, ENT_B, ENT_A, ENT_C, ENT_A, ENT_B};
  localparam logic [1:0] PAIR_Y [NPAIR] = '{ENT_C, ENT_D, ENT_B, ENT_D, ENT_D, ENT_C};

  // Lorentz matrix columns.
  typedef logic [1:0] col_t;
  localparam col_t COL0 = 2'd0;
  localparam col_t COL1 = 2'd1;
  localparam col_t COL2 = 2'd2;
  localparam col_t COL3 = 2'd3;

  // Products of one entry with itself.
  typedef struct packed {
    logic signed [PROD_W-1:0] rr;
    logic signed [PROD_W-1:0] ii;
  } nprod_t;

  // Products of a pair of entries: xr*yr, xi*yi, xi*yr, xr*yi.
  typedef struct packed {
    logic signed [PROD_W-1:0] rr;
    logic signed [PROD_W-1:0] ii;
    logic signed [PROD_W-1:0] ir;
    logic signed [PROD_W-1:0] ri;
  } cprod_t;

  // Squared norms and real / imaginary parts of x * conj(y).
  typedef struct packed {
    logic signed [QNT_W-1:0] na;
    logic signed [QNT_W-1:0] nb;
    logic signed [QNT_W-1:0] nc;
    logic signed [QNT_W-1:0] nd;
    logic signed [QNT_W-1:0] rac;
    logic signed [QNT_W-1:0] iac;
    logic signed [QNT_W-1:0] rbd;
    logic signed [QNT_W-1:0] ibd;
    logic signed [QNT_W-1:0] rab;
    logic signed [QNT_W-1:0] iab;
    logic signed [QNT_W-1:0] rcd;
    logic signed [QNT_W-1:0] icd;
    logic signed [QNT_W-1:0] rad;
    logic signed [QNT_W-1:0] iad;
    logic signed [QNT_W-1:0] rbc;
    logic signed [QNT_W-1:0] ibc;
  } quant_t;

  function automatic logic signed [QNT_W-1:0] ext_prod(input logic signed [PROD_W-1:0] v);
    return {v[PROD_W-1], v};
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_qnt(input logic signed [QNT_W-1:0] v);
    return {{(SUM_W-QNT_W){v[QNT_W-1]}}, v};
  endfunction

endpackage

@@ hdl/sl2l_col_mix.sv @@
// ---------------------------------------------------------------------------
// sl2l_col_mix
// Combines the registered norms and cross terms into the four rows of one
// Lorentz matrix column and scales them to Q24.24 with floor shifts.
// ---------------------------------------------------------------------------
module sl2l_col_mix
  import sl2l_pkg::*;
(
  input  quant_t                   q,
  input  col_t                     col,
  input  logic                     reversing,
  output logic signed [ROW_W-1:0]  row_zero,
  output logic signed [ROW_W-1:0]  row_one,
  output logic signed [ROW_W-1:0]  row_two,
  output logic signed [ROW_W-1:0]  row_three
);

  logic signed [SUM_W-1:0] na, nb, nc, nd;
  logic signed [SUM_W-1:0] rac, iac, rbd, ibd, rab, iab, rcd, icd, rad, iad, rbc, ibc;
  logic signed [SUM_W-1:0] s0, s1, s2, s3;

  always_comb begin
    na  = ext_qnt(q.na);
    nb  = ext_qnt(q.nb);
    nc  = ext_qnt(q.nc);
    nd  = ext_qnt(q.nd);
    rac = ext_qnt(q.rac);
    iac = ext_qnt(q.iac);
    rbd = ext_qnt(q.rbd);
    ibd = ext_qnt(q.ibd);
    rab = ext_qnt(q.rab);
    iab = ext_qnt(q.iab);
    rcd = ext_qnt(q.rcd);
    icd = ext_qnt(q.icd);
    rad = ext_qnt(q.rad);
    iad = ext_qnt(q.iad);
    rbc = ext_qnt(q.rbc);
    ibc = ext_qnt(q.ibc);

    case (col)
      COL0: begin
        s0 = na + nb + nc + nd;
        s1 = na + nb - nc - nd;
        s2 = rac + rbd;
        s3 = iac + ibd;
      end
      COL1: begin
        s0 = na - nb + nc - nd;
        s1 = na - nb - nc + nd;
        s2 = rac - rbd;
        s3 = iac - ibd;
      end
      COL2: begin
        // Doubled so that rows zero and one can share the 1/2 shift.
        s0 = (rab + rcd) <<< 1;
        s1 = (rab - rcd) <<< 1;
        s2 = rad + rbc;
        s3 = iad + ibc;
      end
      default: begin
        s0 = -((iab + icd) <<< 1);
        s1 = (icd - iab) <<< 1;
        s2 = ibc - iad;
        s3 = rad - rbc;
        // Reversal negates the exact sum, so the floor shift sees -x.
        if (reversing) begin
          s0 = -s0;
          s1 = -s1;
          s2 = -s2;
          s3 = -s3;
        end
      end
    endcase
  end

  assign row_zero  = s0[SH_HALF +: ROW_W];
  assign row_one   = s1[SH_HALF +: ROW_W];
  assign row_two   = s2[SH_FULL +: ROW_W];
  assign row_three = s3[SH_FULL +: ROW_W];

endmodule

@@ hdl/sl2c_to_lorentz_matrix.sv @@
// ---------------------------------------------------------------------------
// sl2c_to_lorentz_matrix
// Converts a 2x2 complex matrix in Q8.24 to its 4x4 Lorentz matrix, one
// Q24.24 column per result.
// ---------------------------------------------------------------------------
// Each accepted request produces four results, columns 0 to 3 in order, with
// out_last set on column 3. The block is a short pipeline: an input register,
// a register of all 32-bit by 32-bit products, a register of the norms and
// cross terms, and the result register. A request passes through these registers
// in that order. The quantity register is held for the four column beats of
// the result port, so a new request reaches it only after column 3 is loaded;
// the next request is accepted and multiplied meanwhile, and a stalled result
// does not stop the input side until the pipeline is full.
module sl2c_to_lorentz_matrix
  import sl2l_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  in_a_re,
  input  logic signed [IN_W-1:0]  in_a_im,
  input  logic signed [IN_W-1:0]  in_b_re,
  input  logic signed [IN_W-1:0]  in_b_im,
  input  logic signed [IN_W-1:0]  in_c_re,
  input  logic signed [IN_W-1:0]  in_c_im,
  input  logic signed [IN_W-1:0]  in_d_re,
  input  logic signed [IN_W-1:0]  in_d_im,
  input  logic                    in_reversing,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ROW_W-1:0] out_row_zero,
  output logic signed [ROW_W-1:0] out_row_one,
  output logic signed [ROW_W-1:0] out_row_two,
  output logic signed [ROW_W-1:0] out_row_three,
  output logic [1:0]              out_column,
  output logic                    out_last
);

  // Pipeline control.
  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt, ov_r, ov_nxt;
  col_t col_r, col_nxt;
  logic en1, en2, en3, out_load;

  // Payload.
  logic signed [IN_W-1:0] ent_re_r [4];
  logic signed [IN_W-1:0] ent_im_r [4];
  logic                   rev1_r, rev2_r, rev3_r;
  nprod_t                 nprod_r [4];
  cprod_t                 cprod_r [NPAIR];
  quant_t                 quant_nxt, quant_r;
  logic signed [ROW_W-1:0] row0_nxt, row1_nxt, row2_nxt, row3_nxt;
  logic signed [ROW_W-1:0] row0_r, row1_r, row2_r, row3_r;
  col_t                   ocol_r;

  assign out_load = v3_r && (!ov_r || out_ready);
  assign en3      = !v3_r || (out_load && col_r == COL3);
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_comb begin
    v1_nxt  = en1 ? in_valid : v1_r;
    v2_nxt  = en2 ? v1_r : v2_r;
    v3_nxt  = en3 ? v2_r : v3_r;
    col_nxt = col_r;
    if (en3) begin
      col_nxt = COL0;
    end else if (out_load) begin
      col_nxt = col_r + col_t'(1);
    end
    ov_nxt = ov_r;
    if (out_load) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      ov_r  <= 1'b0;
      col_r <= COL0;
    end else begin
      v1_r  <= v1_nxt;
      v2_r  <= v2_nxt;
      v3_r  <= v3_nxt;
      ov_r  <= ov_nxt;
      col_r <= col_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (en1) begin
      ent_re_r[ENT_A] <= in_a_re;
      ent_im_r[ENT_A] <= in_a_im;
      ent_re_r[ENT_B] <= in_b_re;
      ent_im_r[ENT_B] <= in_b_im;
      ent_re_r[ENT_C] <= in_c_re;
      ent_im_r[ENT_C] <= in_c_im;
      ent_re_r[ENT_D] <= in_d_re;
      ent_im_r[ENT_D] <= in_d_im;
      rev1_r          <= in_reversing;
    end
  end

  // Product register: every product is exact in 64 bits.
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int k = 0; k < 4; k++) begin
        nprod_r[k].rr <= PROD_W'(ent_re_r[k]) * PROD_W'(ent_re_r[k]);
        nprod_r[k].ii <= PROD_W'(ent_im_r[k]) * PROD_W'(ent_im_r[k]);
      end
      for (int p = 0; p < NPAIR; p++) begin
        cprod_r[p].rr <= PROD_W'(ent_re_r[PAIR_X[p]]) * PROD_W'(ent_re_r[PAIR_Y[p]]);
        cprod_r[p].ii <= PROD_W'(ent_im_r[PAIR_X[p]]) * PROD_W'(ent_im_r[PAIR_Y[p]]);
        cprod_r[p].ir <= PROD_W'(ent_im_r[PAIR_X[p]]) * PROD_W'(ent_re_r[PAIR_Y[p]]);
        cprod_r[p].ri <= PROD_W'(ent_re_r[PAIR_X[p]]) * PROD_W'(ent_im_r[PAIR_Y[p]]);
      end
      rev2_r <= rev1_r;
    end
  end

  // Re(x conj y) = xr*yr + xi*yi, Im(x conj y) = xi*yr - xr*yi.
  always_comb begin
    quant_nxt.na  = ext_prod(nprod_r[ENT_A].rr) + ext_prod(nprod_r[ENT_A].ii);
    quant_nxt.nb  = ext_prod(nprod_r[ENT_B].rr) + ext_prod(nprod_r[ENT_B].ii);
    quant_nxt.nc  = ext_prod(nprod_r[ENT_C].rr) + ext_prod(nprod_r[ENT_C].ii);
    quant_nxt.nd  = ext_prod(nprod_r[ENT_D].rr) + ext_prod(nprod_r[ENT_D].ii);
    quant_nxt.rac = ext_prod(cprod_r[PR_AC].rr) + ext_prod(cprod_r[PR_AC].ii);
    quant_nxt.iac = ext_prod(cprod_r[PR_AC].ir) - ext_prod(cprod_r[PR_AC].ri);
    quant_nxt.rbd = ext_prod(cprod_r[PR_BD].rr) + ext_prod(cprod_r[PR_BD].ii);
    quant_nxt.ibd = ext_prod(cprod_r[PR_BD].ir) - ext_prod(cprod_r[PR_BD].ri);
    quant_nxt.rab = ext_prod(cprod_r[PR_AB].rr) + ext_prod(cprod_r[PR_AB].ii);
    quant_nxt.iab = ext_prod(cprod_r[PR_AB].ir) - ext_prod(cprod_r[PR_AB].ri);
    quant_nxt.rcd = ext_prod(cprod_r[PR_CD].rr) + ext_prod(cprod_r[PR_CD].ii);
    quant_nxt.icd = ext_prod(cprod_r[PR_CD].ir) - ext_prod(cprod_r[PR_CD].ri);
    quant_nxt.rad = ext_prod(cprod_r[PR_AD].rr) + ext_prod(cprod_r[PR_AD].ii);
    quant_nxt.iad = ext_prod(cprod_r[PR_AD].ir) - ext_prod(cprod_r[PR_AD].ri);
    quant_nxt.rbc = ext_prod(cprod_r[PR_BC].rr) + ext_prod(cprod_r[PR_BC].ii);
    quant_nxt.ibc = ext_prod(cprod_r[PR_BC].ir) - ext_prod(cprod_r[PR_BC].ri);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      quant_r <= quant_nxt;
      rev3_r  <= rev2_r;
    end
  end

  sl2l_col_mix u_col_mix (
    .q         (quant_r),
    .col       (col_r),
    .reversing (rev3_r),
    .row_zero  (row0_nxt),
    .row_one   (row1_nxt),
    .row_two   (row2_nxt),
    .row_three (row3_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      row0_r <= row0_nxt;
      row1_r <= row1_nxt;
      row2_r <= row2_nxt;
      row3_r <= row3_nxt;
      ocol_r <= col_r;
    end
  end

  assign out_valid     = ov_r;
  assign out_row_zero  = row0_r;
  assign out_row_one   = row1_r;
  assign out_row_two   = row2_r;
  assign out_row_three = row3_r;
  assign out_column    = ocol_r;
  assign out_last      = (ocol_r == COL3);

endmodule

@@ hdl/sl2l_checker.sv @@
// ---------------------------------------------------------------------------
// sl2l_checker
// Port-level checks of the converter: column sequencing, the last marker,
// reset behavior and a stalled result holding.
// ---------------------------------------------------------------------------
module sl2l_checker
  import sl2l_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic signed [IN_W-1:0]  in_a_re,
  input logic signed [IN_W-1:0]  in_a_im,
  input logic signed [IN_W-1:0]  in_b_re,
  input logic signed [IN_W-1:0]  in_b_im,
  input logic signed [IN_W-1:0]  in_c_re,
  input logic signed [IN_W-1:0]  in_c_im,
  input logic signed [IN_W-1:0]  in_d_re,
  input logic signed [IN_W-1:0]  in_d_im,
  input logic                    in_reversing,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [ROW_W-1:0] out_row_zero,
  input logic signed [ROW_W-1:0] out_row_one,
  input logic signed [ROW_W-1:0] out_row_two,
  input logic signed [ROW_W-1:0] out_row_three,
  input logic [1:0]              out_column,
  input logic                    out_last
);

  // The cycle after reset no result may be shown.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The last marker goes with the final column and no other.
  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_column == COL3)))
    else $error("last marker does not match column");

  // Columns of one matrix follow each other without a gap.
  a_col_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && out_column == $past(out_column) + 2'd1)
    else $error("column sequence broken");

  // A stalled result holds its column and rows zero and three.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_column) && $stable(out_row_zero) && $stable(out_row_three))
    else $error("stalled result changed");

endmodule

bind sl2c_to_lorentz_matrix sl2l_checker u_sl2l_checker (.*);
